FILE: rtl/core/bdc_pkg.sv
// Package for the button debounce and tap/hold classifier.
// Holds the request, result, state and configuration types and register indexes.
// No dependencies.
package bdc_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TAP_THR   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_END_HOLD  = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
	localparam logic [CFG_W-1:0] TAP_THR_RST  = 16'd250;
	localparam logic [CFG_W-1:0] END_HOLD_RST = 16'd800;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] tap_threshold_ms;
		logic [CFG_W-1:0] end_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic              raw_pressed;
		logic [TIME_W-1:0] now_ms;
		logic              inject_tap;
		logic              ack_tap;
		logic              ack_press;
		logic              ack_end_hold;
	} req_t;

	typedef struct packed {
		logic tap_event;
		logic press_event;
		logic end_hold_event;
		logic talk_held;
	} res_t;

	typedef struct packed {
		logic              raw_level;
		logic [TIME_W-1:0] level_change_time;
		logic              stable_level;
		logic [TIME_W-1:0] press_start_time;
		logic              talk_latch;
		logic              end_hold_latch;
		logic              press_flag;
		logic              tap_flag;
		logic              end_hold_flag;
	} state_t;

endpackage

FILE: rtl/core/bdc_req_if.sv
// Request channel of the button classifier: valid/ready plus one sampled button request.
// Depends on bdc_pkg for the time width.
interface bdc_req_if;
	import bdc_pkg::*;

	logic              valid;
	logic              ready;
	logic              raw_pressed;
	logic [TIME_W-1:0] now_ms;
	logic              inject_tap;
	logic              ack_tap;
	logic              ack_press;
	logic              ack_end_hold;

	modport source (
		output valid, raw_pressed, now_ms, inject_tap, ack_tap, ack_press, ack_end_hold,
		input  ready
	);
	modport sink (
		input  valid, raw_pressed, now_ms, inject_tap, ack_tap, ack_press, ack_end_hold,
		output ready
	);
endinterface

FILE: rtl/core/bdc_res_if.sv
// Result channel of the button classifier: valid/ready plus the four event bits.
// No dependencies.
interface bdc_res_if;
	logic valid;
	logic ready;
	logic tap_event;
	logic press_event;
	logic end_hold_event;
	logic talk_held;

	modport source (
		output valid, tap_event, press_event, end_hold_event, talk_held,
		input  ready
	);
	modport sink (
		input  valid, tap_event, press_event, end_hold_event, talk_held,
		output ready
	);
endinterface

FILE: rtl/core/bdc_cfg.sv
// Configuration register file: debounce, tap threshold and end-hold times.
// Depends on bdc_pkg.
module bdc_cfg
	import bdc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.tap_threshold_ms <= TAP_THR_RST;
			cfg_q.end_hold_ms      <= END_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms      <= cfg_wdata;
				REG_TAP_THR:  cfg_q.tap_threshold_ms <= cfg_wdata;
				REG_END_HOLD: cfg_q.end_hold_ms      <= cfg_wdata;
				default: ;  // writes to unused indexes are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bdc_step.sv
// Next-state and result logic for one button request: debounce, press/tap/talk
// classification, end-hold detection and acknowledge clearing. Depends on bdc_pkg.
module bdc_step
	import bdc_pkg::*;
(
	input  state_t cur,
	input  req_t   req,
	input  cfg_t   cfg,
	output state_t nxt,
	output res_t   res
);

	logic              lvl;
	logic [TIME_W-1:0] lct_n;
	logic [TIME_W-1:0] db_age;
	logic              flip;
	logic              stable_n;
	logic [TIME_W-1:0] pst_n;
	logic [TIME_W-1:0] hold_age;
	logic              talk_n;
	logic              eh_trig;
	logic              tap_n;
	logic              press_n;
	logic              ehf_n;

	always_comb begin
		lvl    = req.raw_pressed;
		lct_n  = (lvl != cur.raw_level) ? req.now_ms : cur.level_change_time;
		db_age = req.now_ms - lct_n;
		flip   = (lvl != cur.stable_level) &&
			(db_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});

		stable_n = flip ? lvl : cur.stable_level;
		pst_n    = (flip && lvl) ? req.now_ms : cur.press_start_time;
		press_n  = cur.press_flag | (flip & lvl);
		// A release counts as a tap only when talk was never latched for this press.
		tap_n    = cur.tap_flag | (flip & ~lvl & ~cur.talk_latch) | req.inject_tap;

		hold_age = req.now_ms - pst_n;
		talk_n   = (flip ? 1'b0 : cur.talk_latch) |
			(stable_n & (hold_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.tap_threshold_ms}));
		eh_trig  = stable_n & ~cur.end_hold_latch &
			(hold_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.end_hold_ms});
		ehf_n    = cur.end_hold_flag | eh_trig;

		res.tap_event      = tap_n;
		res.press_event    = press_n;
		res.end_hold_event = ehf_n;
		res.talk_held      = talk_n & stable_n;

		nxt.raw_level         = lvl;
		nxt.level_change_time = lct_n;
		nxt.stable_level      = stable_n;
		nxt.press_start_time  = pst_n;
		nxt.talk_latch        = talk_n;
		nxt.end_hold_latch    = (cur.end_hold_latch | eh_trig) & stable_n;
		nxt.press_flag        = press_n & ~req.ack_press;
		nxt.tap_flag          = tap_n & ~req.ack_tap;
		nxt.end_hold_flag     = ehf_n & ~req.ack_end_hold;
	end

endmodule

FILE: rtl/core/button_debounce_tap_hold_classifier.sv
// Top level of the button debounce and tap/hold classifier.
// Depends on bdc_pkg, bdc_req_if, bdc_res_if, bdc_cfg and bdc_step.
//
// Usage: every request on the req channel carries one sampled button level with
// its millisecond timestamp, an inject-tap bit and three acknowledge bits. For
// each request exactly one result leaves on the res channel with the pending
// tap, press and end-hold events and the talk-held level. Both channels use a
// valid/ready handshake; a transfer happens on a rising edge with both high.
// A request taken on an edge is held in the input register; when it advances,
// its result is loaded into the output register, where it is offered to the
// receiver. Throughput is one request per cycle while the receiver keeps
// res.ready high; it is set by the classifier update, since each request
// needs the full state left by the previous one.
// While the receiver stalls, the output register keeps its result and the input
// register keeps the next request; further requests are refused until the
// result is taken. No state changes while a request waits. Reset (arst_n low)
// clears all classifier state and event flags, empties both registers and loads
// the default times (30, 250 and 800 ms). The user must write the three times
// via cfg_we/cfg_index/cfg_wdata only while idle; it is not enforced.
module button_debounce_tap_hold_classifier
	import bdc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	bdc_req_if.sink              req,
	bdc_res_if.source            res
);

	cfg_t   cfg;
	state_t state_q;
	state_t state_nxt;
	req_t   req_s1;
	logic   valid_s1;
	res_t   res_comb;
	res_t   res_s2;
	logic   valid_s2;
	logic   advance;
	logic   take;

	bdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bdc_step u_step (
		.cur (state_q),
		.req (req_s1),
		.cfg (cfg),
		.nxt (state_nxt),
		.res (res_comb)
	);

	// The held request moves on when the output register is empty or being drained.
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.raw_pressed  <= req.raw_pressed;
			req_s1.now_ms       <= req.now_ms;
			req_s1.inject_tap   <= req.inject_tap;
			req_s1.ack_tap      <= req.ack_tap;
			req_s1.ack_press    <= req.ack_press;
			req_s1.ack_end_hold <= req.ack_end_hold;
		end
	end

	// Classifier state is committed only when its result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign res.valid          = valid_s2;
	assign res.tap_event      = res_s2.tap_event;
	assign res.press_event    = res_s2.press_event;
	assign res.end_hold_event = res_s2.end_hold_event;
	assign res.talk_held      = res_s2.talk_held;

`ifndef SYNTH
	// Talk can only be latched while the debounced level is pressed.
	a_talk_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.talk_latch |-> state_q.stable_level)
		else $error("talk latch set while button released");

	// The end-hold latch is dropped on every debounced release.
	a_eh_latch_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.end_hold_latch |-> state_q.stable_level)
		else $error("end-hold latch set while button released");

	// The state only moves when a request is turned into a result.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("classifier state changed without a request");

	// An acknowledged tap never stays pending.
	a_tap_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.ack_tap) |=> !state_q.tap_flag)
		else $error("tap flag survived its acknowledge");
`endif

endmodule
